>>> sv/quad_vertex_clockwise_order_macros.svh
// Assertion macros shared by the quad vertex ordering RTL
`ifndef QUAD_VERTEX_CLOCKWISE_ORDER_MACROS_SVH
`define QUAD_VERTEX_CLOCKWISE_ORDER_MACROS_SVH

// Check that cond holds whenever trig holds, on the same edge
`define QVCO_ASSERT_SAME(label, trig, cond, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (trig) |-> (cond)) \
		else $error(msg);

// Check that cond holds on the edge after trig
`define QVCO_ASSERT_NEXT(label, trig, cond, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (trig) |=> (cond)) \
		else $error(msg);

`endif

>>> sv/qvco_pkg.sv
// Types and constants of the quad vertex ordering block
package qvco_pkg;

	typedef logic [1:0] idx_t;
	typedef logic [3:0][3:0] mat_t;

	// direction class of a vertex seen from the pivot, in clockwise order
	typedef enum logic [1:0] {
		CLS_ZERO,
		CLS_RIGHT,
		CLS_BELOW,
		CLS_LEFT
	} cls_t;

	// corner signs of the role sum, 1 = plus
	localparam logic [3:0] CORNER_SX = 4'b1001;
	localparam logic [3:0] CORNER_SY = 4'b0011;

endpackage

>>> sv/qvco_if.sv
// Valid/ready channel carrying four vertices
interface qvco_if #(
	parameter int W = 16
);
	logic         valid;
	logic         ready;
	logic [W-1:0] x0;
	logic [W-1:0] y0;
	logic [W-1:0] x1;
	logic [W-1:0] y1;
	logic [W-1:0] x2;
	logic [W-1:0] y2;
	logic [W-1:0] x3;
	logic [W-1:0] y3;

	modport source (output valid, x0, y0, x1, y1, x2, y2, x3, y3, input ready);
	modport sink (input valid, x0, y0, x1, y1, x2, y2, x3, y3, output ready);
endinterface

>>> sv/qvco_sort.sv
// Reference angle pick and rank sort of four vertices
module qvco_sort
	import qvco_pkg::*;
(
	input  mat_t       gt,
	input  mat_t       dlt,
	input  logic [3:0] dmax,
	output idx_t       ord [4]
);

	logic [1:0] ref_idx;
	logic       found;
	logic       largest;
	mat_t       bef;
	logic [2:0] rank [4];

	always_comb begin
		ref_idx = '0;
		found   = 1'b0;
		for (int i = 0; i < 4; i++) begin
			if (dmax[i] && (!found || gt[i][ref_idx])) begin
				ref_idx = 2'(i);
				found   = 1'b1;
			end
		end
		largest = 1'b1;
		for (int i = 0; i < 4; i++) begin
			if (gt[i][ref_idx]) largest = 1'b0;
		end
		for (int i = 0; i < 4; i++) begin
			for (int j = 0; j < 4; j++) begin
				if (gt[j][i]) bef[i][j] = 1'b1;
				else if (gt[i][j]) bef[i][j] = 1'b0;
				else if (gt[ref_idx][i]) bef[i][j] = dlt[i][j];
				else if (gt[i][ref_idx]) bef[i][j] = dlt[j][i];
				else bef[i][j] = largest ? dlt[j][i] : dlt[i][j];
			end
		end
		// stable rank: count those that go first, earlier index wins a tie
		for (int i = 0; i < 4; i++) begin
			rank[i] = '0;
			for (int j = 0; j < 4; j++) begin
				if (j != i && (bef[j][i] || (!bef[i][j] && j < i))) rank[i] = rank[i] + 3'd1;
			end
		end
		for (int k = 0; k < 4; k++) ord[k] = '0;
		for (int i = 0; i < 4; i++) ord[rank[i][1:0]] = 2'(i);
	end

endmodule

>>> sv/quad_vertex_clockwise_order.sv
// Top level: clockwise ordering of the four vertices of a quadrilateral
//
// Channels: quad (sink) takes one word of four vertices x0,y0..x3,y3; ordered
// (source) returns one word with the same vertices in the roles top-left,
// top-right, bottom-right, bottom-left, going clockwise.
// Pivot is the topmost vertex (first index on a tie in y); vertices sort by
// clockwise angle from straight up, angle ties by Manhattan distance, then the
// circular shift with the smallest signed corner sum is emitted.
// Pipeline: six register stages; the first loads at the acceptance edge.
// Throughput: one word per cycle while ordered is not stalled; the pipeline
// (pivot and offsets, cross products, subtract and distance compare, rank
// sort, gather and corner sums, minimum pick) takes a new word every cycle
// unless it is frozen by a stall.
// Stall: when ordered holds a word not taken, the whole pipe freezes and
// quad.ready drops; nothing is lost or repeated. Bubbles pass as invalid
// stages, and an empty output stage lets the pipe advance.
// Reset: arst_n clears all stage valid bits; payload is not reset.
module quad_vertex_clockwise_order
	import qvco_pkg::*;
#(
	parameter int COORD_BITS = 16
) (
	input logic    clk,
	input logic    arst_n,
	qvco_if.sink   quad,
	qvco_if.source ordered
);

`include "quad_vertex_clockwise_order_macros.svh"

	localparam int W  = COORD_BITS;
	localparam int DW = W + 1;      // offset (signed) and distance width
	localparam int PW = 2 * DW;     // product width
	localparam int CW = PW + 1;     // cross product width
	localparam int SW = W + 3;      // corner sum width

	logic en;

	// advance the whole pipe when the output stage is free or taken
	assign en         = !ordered.valid || ordered.ready;
	assign quad.ready = en;

	// stage 1: pivot, offsets, distance, class
	logic [W-1:0]         xi [4];
	logic [W-1:0]         yi [4];
	logic [1:0]           top;
	logic signed [DW-1:0] ux_c [4];
	logic signed [DW-1:0] uy_c [4];
	logic [DW-1:0]        ax_c [4];
	logic [DW-1:0]        ay_c [4];
	cls_t                 cls_c [4];

	logic                 v_s1;
	logic [W-1:0]         x_s1 [4];
	logic [W-1:0]         y_s1 [4];
	logic signed [DW-1:0] ux_s1 [4];
	logic signed [DW-1:0] uy_s1 [4];
	logic [DW-1:0]        dist_s1 [4];
	cls_t                 cls_s1 [4];

	assign xi[0] = quad.x0;
	assign xi[1] = quad.x1;
	assign xi[2] = quad.x2;
	assign xi[3] = quad.x3;
	assign yi[0] = quad.y0;
	assign yi[1] = quad.y1;
	assign yi[2] = quad.y2;
	assign yi[3] = quad.y3;

	always_comb begin
		top = '0;
		for (int i = 1; i < 4; i++) begin
			if (yi[i] < yi[top]) top = 2'(i);
		end
		for (int i = 0; i < 4; i++) begin
			ux_c[i] = $signed({1'b0, xi[i]}) - $signed({1'b0, xi[top]});
			uy_c[i] = $signed({1'b0, yi[i]}) - $signed({1'b0, yi[top]});
			ax_c[i] = ux_c[i][DW-1] ? DW'(-ux_c[i]) : DW'(ux_c[i]);
			ay_c[i] = uy_c[i][DW-1] ? DW'(-uy_c[i]) : DW'(uy_c[i]);
			if (ux_c[i] == '0 && uy_c[i] == '0) cls_c[i] = CLS_ZERO;
			else if (uy_c[i] == '0) cls_c[i] = ux_c[i][DW-1] ? CLS_LEFT : CLS_RIGHT;
			else cls_c[i] = CLS_BELOW;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
		end else if (en) begin
			v_s1 <= quad.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			for (int i = 0; i < 4; i++) begin
				x_s1[i]    <= xi[i];
				y_s1[i]    <= yi[i];
				ux_s1[i]   <= ux_c[i];
				uy_s1[i]   <= uy_c[i];
				dist_s1[i] <= ax_c[i] + ay_c[i];
				cls_s1[i]  <= cls_c[i];
			end
		end
	end

	// stage 2: cross product halves for each pair i < j
	logic                 v_s2;
	logic [W-1:0]         x_s2 [4];
	logic [W-1:0]         y_s2 [4];
	logic [DW-1:0]        dist_s2 [4];
	cls_t                 cls_s2 [4];
	logic signed [PW-1:0] pa_s2 [4][4];
	logic signed [PW-1:0] pb_s2 [4][4];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s2 <= 1'b0;
		end else if (en) begin
			v_s2 <= v_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			for (int i = 0; i < 4; i++) begin
				x_s2[i]    <= x_s1[i];
				y_s2[i]    <= y_s1[i];
				dist_s2[i] <= dist_s1[i];
				cls_s2[i]  <= cls_s1[i];
				for (int j = 0; j < 4; j++) begin
					if (i < j) begin
						pa_s2[i][j] <= ux_s1[i] * uy_s1[j];
						pb_s2[i][j] <= uy_s1[i] * ux_s1[j];
					end else begin
						pa_s2[i][j] <= '0;
						pb_s2[i][j] <= '0;
					end
				end
			end
		end
	end

	// stage 3: cross sign, distance order, farthest set
	logic signed [CW-1:0] crs_c [4][4];
	logic                 v_s3;
	logic [W-1:0]         x_s3 [4];
	logic [W-1:0]         y_s3 [4];
	cls_t                 cls_s3 [4];
	mat_t                 pos_s3;
	mat_t                 neg_s3;
	mat_t                 dlt_s3;
	logic [3:0]           dmax_s3;

	always_comb begin
		for (int i = 0; i < 4; i++) begin
			for (int j = 0; j < 4; j++) begin
				crs_c[i][j] = CW'(pa_s2[i][j]) - CW'(pb_s2[i][j]);
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s3 <= 1'b0;
		end else if (en) begin
			v_s3 <= v_s2;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			for (int i = 0; i < 4; i++) begin
				x_s3[i]    <= x_s2[i];
				y_s3[i]    <= y_s2[i];
				cls_s3[i]  <= cls_s2[i];
				dmax_s3[i] <= (dist_s2[i] >= dist_s2[0]) && (dist_s2[i] >= dist_s2[1])
					&& (dist_s2[i] >= dist_s2[2]) && (dist_s2[i] >= dist_s2[3]);
				for (int j = 0; j < 4; j++) begin
					pos_s3[i][j] <= !crs_c[i][j][CW-1] && (crs_c[i][j] != '0);
					neg_s3[i][j] <= crs_c[i][j][CW-1];
					dlt_s3[i][j] <= dist_s2[i] < dist_s2[j];
				end
			end
		end
	end

	// stage 4: angle order and rank sort
	mat_t       gt_c;
	idx_t       ord_c [4];
	logic       v_s4;
	logic [W-1:0] x_s4 [4];
	logic [W-1:0] y_s4 [4];
	idx_t       ord_s4 [4];
	logic [3:0] ord_seen;

	// gt_c[i][j]: angle of vertex i lies clockwise past that of vertex j
	always_comb begin
		for (int i = 0; i < 4; i++) begin
			for (int j = 0; j < 4; j++) begin
				if (i == j) gt_c[i][j] = 1'b0;
				else if (cls_s3[i] != cls_s3[j]) gt_c[i][j] = cls_s3[i] > cls_s3[j];
				else if (cls_s3[i] != CLS_BELOW) gt_c[i][j] = 1'b0;
				else if (i < j) gt_c[i][j] = neg_s3[i][j];
				else gt_c[i][j] = pos_s3[j][i];
			end
		end
	end

	qvco_sort u_sort (
		.gt   (gt_c),
		.dlt  (dlt_s3),
		.dmax (dmax_s3),
		.ord  (ord_c)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s4 <= 1'b0;
		end else if (en) begin
			v_s4 <= v_s3;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			for (int i = 0; i < 4; i++) begin
				x_s4[i]   <= x_s3[i];
				y_s4[i]   <= y_s3[i];
				ord_s4[i] <= ord_c[i];
			end
		end
	end

	always_comb begin
		ord_seen = '0;
		for (int k = 0; k < 4; k++) ord_seen[ord_s4[k]] = 1'b1;
	end

	// stage 5: gather sorted vertices, corner sum of each shift
	logic [W-1:0]         px_c [4];
	logic [W-1:0]         py_c [4];
	logic signed [SW-1:0] sum_c [4];
	logic signed [SW-1:0] tx;
	logic signed [SW-1:0] ty;
	logic                 v_s5;
	logic [W-1:0]         px_s5 [4];
	logic [W-1:0]         py_s5 [4];
	logic signed [SW-1:0] sum_s5 [4];

	always_comb begin
		tx = '0;
		ty = '0;
		for (int k = 0; k < 4; k++) begin
			px_c[k] = x_s4[ord_s4[k]];
			py_c[k] = y_s4[ord_s4[k]];
		end
		for (int k = 0; k < 4; k++) begin
			sum_c[k] = '0;
			for (int i = 0; i < 4; i++) begin
				tx = $signed(SW'(px_c[2'(i + k)]));
				ty = $signed(SW'(py_c[2'(i + k)]));
				sum_c[k] = sum_c[k] + (CORNER_SX[i] ? tx : -tx) + (CORNER_SY[i] ? ty : -ty);
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s5 <= 1'b0;
		end else if (en) begin
			v_s5 <= v_s4;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			for (int k = 0; k < 4; k++) begin
				px_s5[k]  <= px_c[k];
				py_s5[k]  <= py_c[k];
				sum_s5[k] <= sum_c[k];
			end
		end
	end

	// stage 6: smallest sum, first shift on a tie; rotate into the output word
	logic [1:0]           best;
	logic signed [SW-1:0] best_sum;
	logic                 v_s6;
	logic [W-1:0]         ox_s6 [4];
	logic [W-1:0]         oy_s6 [4];

	always_comb begin
		best     = '0;
		best_sum = sum_s5[0];
		for (int k = 1; k < 4; k++) begin
			if (sum_s5[k] < best_sum) begin
				best     = 2'(k);
				best_sum = sum_s5[k];
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s6 <= 1'b0;
		end else if (en) begin
			v_s6 <= v_s5;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			for (int i = 0; i < 4; i++) begin
				ox_s6[i] <= px_s5[2'(i) + best];
				oy_s6[i] <= py_s5[2'(i) + best];
			end
		end
	end

	assign ordered.valid = v_s6;
	assign ordered.x0    = ox_s6[0];
	assign ordered.y0    = oy_s6[0];
	assign ordered.x1    = ox_s6[1];
	assign ordered.y1    = oy_s6[1];
	assign ordered.x2    = ox_s6[2];
	assign ordered.y2    = oy_s6[2];
	assign ordered.x3    = ox_s6[3];
	assign ordered.y3    = oy_s6[3];

	// pivot is topmost, so no vertex lies above it
	`QVCO_ASSERT_SAME(a_pivot_top, v_s1, !uy_s1[0][DW-1] && !uy_s1[1][DW-1] && !uy_s1[2][DW-1] && !uy_s1[3][DW-1], "vertex above pivot")
	// sort result must be a permutation of the four vertices
	`QVCO_ASSERT_SAME(a_ord_perm, v_s4, ord_seen == 4'hF, "sort order is not a permutation")
	// a stalled word inside the pipe stays valid
	`QVCO_ASSERT_NEXT(a_stall_keep, v_s5 && !en, v_s5, "word dropped during stall")

endmodule

>>> tb/sv/tb_quad_vertex_clockwise_order.sv
// Testbench for the quad vertex clockwise ordering block
`timescale 1ns / 1ps
module tb_quad_vertex_clockwise_order
	import qvco_pkg::*;
();

	localparam int CB = 16;
	typedef logic [CB-1:0] coord_t;

	// One quad: four vertices, all x coordinates then all y coordinates
	typedef struct {
		coord_t x[4];
		coord_t y[4];
	} quad_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;

	qvco_if #(.W(CB)) quad ();
	qvco_if #(.W(CB)) ordered ();

	quad_vertex_clockwise_order #(.COORD_BITS(CB)) dut (
		.clk(clk),
		.arst_n(arst_n),
		.quad(quad),
		.ordered(ordered)
	);

	always #4 clk = ~clk;

	quad_t pending_quads[$];
	quad_t expected_orders[$];
	int fail_count = 0;
	bit stim_done = 0;
	bit quiet_tail = 0;
	bit hold_sender = 0;
	bit quad_taken = 0;

	// Angle class of an offset from the pivot, in clockwise order
	function automatic cls_t dir_class(longint ux, longint uy);
		if (ux == 0 && uy == 0)
			return CLS_ZERO;
		if (uy == 0)
			return (ux > 0) ? CLS_RIGHT : CLS_LEFT;
		return CLS_BELOW;
	endfunction

	// -1, 0, +1 as the angle of offset a is below, equal to, above that of b
	function automatic int cmp_angle(longint ax, longint ay, longint bx, longint by);
		cls_t ca, cb;
		longint cr;
		ca = dir_class(ax, ay);
		cb = dir_class(bx, by);
		if (ca != cb)
			return (ca < cb) ? -1 : 1;
		if (ca != CLS_BELOW)
			return 0;
		cr = ax * by - ay * bx;
		if (cr > 0)
			return -1;
		if (cr < 0)
			return 1;
		return 0;
	endfunction

	// Predict the clockwise order with the best corner shift
	function automatic quad_t order_quad(quad_t q);
		longint ux[4], uy[4], md[4];
		int ord[4];
		int pivot, refv, best_k, v, j, c, cr;
		longint max_d, s, best_s;
		bit top_ref, goes_first;
		quad_t r;
		pivot = 0;
		for (int i = 1; i < 4; i++)
			if (q.y[i] < q.y[pivot])
				pivot = i;
		max_d = 0;
		for (int i = 0; i < 4; i++) begin
			ux[i] = longint'(q.x[i]) - longint'(q.x[pivot]);
			uy[i] = longint'(q.y[i]) - longint'(q.y[pivot]);
			md[i] = (ux[i] < 0 ? -ux[i] : ux[i]) + (uy[i] < 0 ? -uy[i] : uy[i]);
			if (md[i] > max_d)
				max_d = md[i];
		end
		refv = -1;
		for (int i = 0; i < 4; i++)
			if (md[i] == max_d &&
					(refv < 0 || cmp_angle(ux[i], uy[i], ux[refv], uy[refv]) > 0))
				refv = i;
		top_ref = 1;
		for (int i = 0; i < 4; i++)
			if (cmp_angle(ux[i], uy[i], ux[refv], uy[refv]) > 0)
				top_ref = 0;
		for (int i = 0; i < 4; i++)
			ord[i] = i;
		// insertion sort by angle, distance tie-break around the reference angle
		for (int i = 1; i < 4; i++) begin
			v = ord[i];
			j = i;
			while (j > 0) begin
				c = cmp_angle(ux[v], uy[v], ux[ord[j-1]], uy[ord[j-1]]);
				if (c != 0)
					goes_first = (c < 0);
				else begin
					cr = cmp_angle(ux[v], uy[v], ux[refv], uy[refv]);
					if (cr < 0)
						goes_first = md[v] < md[ord[j-1]];
					else if (cr > 0)
						goes_first = md[v] > md[ord[j-1]];
					else
						goes_first = top_ref ? (md[v] > md[ord[j-1]])
							: (md[v] < md[ord[j-1]]);
				end
				if (!goes_first)
					break;
				ord[j] = ord[j-1];
				j--;
			end
			ord[j] = v;
		end
		best_k = 0;
		best_s = 0;
		for (int k = 0; k < 4; k++) begin
			s = 0;
			for (int i = 0; i < 4; i++) begin
				v = ord[(i + k) & 3];
				s += CORNER_SX[i] ? longint'(q.x[v]) : -longint'(q.x[v]);
				s += CORNER_SY[i] ? longint'(q.y[v]) : -longint'(q.y[v]);
			end
			if (k == 0 || s < best_s) begin
				best_s = s;
				best_k = k;
			end
		end
		for (int i = 0; i < 4; i++) begin
			r.x[i] = q.x[ord[(i + best_k) & 3]];
			r.y[i] = q.y[ord[(i + best_k) & 3]];
		end
		return r;
	endfunction

	function automatic quad_t pack_quad(int v[8]);
		quad_t q;
		for (int i = 0; i < 4; i++) begin
			q.x[i] = coord_t'(v[2*i]);
			q.y[i] = coord_t'(v[2*i+1]);
		end
		return q;
	endfunction

	// Random coordinate: mostly small windows, sometimes full range or extremes
	function automatic coord_t rand_coord(int base, int span);
		case ($urandom_range(0, 9))
			0: return coord_t'($urandom);
			1: return $urandom_range(0, 1) ? '1 : '0;
			default: return coord_t'(base + $urandom_range(0, span));
		endcase
	endfunction

	function automatic quad_t rand_quad();
		quad_t q;
		int base, span;
		base = $urandom_range(0, 65535 - 64);
		span = $urandom_range(0, 3) == 0 ? 2 : 63;
		for (int i = 0; i < 4; i++) begin
			q.x[i] = rand_coord(base, span);
			q.y[i] = rand_coord(base, span);
		end
		// sometimes copy a vertex or align one to share a row/column
		if ($urandom_range(0, 3) == 0)
			q.x[$urandom_range(0, 3)] = q.x[$urandom_range(0, 3)];
		if ($urandom_range(0, 3) == 0)
			q.y[$urandom_range(0, 3)] = q.y[$urandom_range(0, 3)];
		if ($urandom_range(0, 7) == 0) begin
			int a, b;
			a = $urandom_range(0, 3);
			b = $urandom_range(0, 3);
			q.x[a] = q.x[b];
			q.y[a] = q.y[b];
		end
		return q;
	endfunction

	// Record whether the presented word was taken at the last rising edge
	always @(posedge clk) begin
		quad_taken <= arst_n && quad.valid && quad.ready;
	end

	// Driver: present words at the falling edge, with random idle bursts
	int send_gap = 0;
	always @(negedge clk) begin
		if (!arst_n) begin
			quad.valid <= 1'b0;
		end else if (quad.valid && !quad_taken) begin
			// hold the word until it is taken
		end else if (send_gap > 0) begin
			send_gap <= send_gap - 1;
			quad.valid <= 1'b0;
		end else if (pending_quads.size() > 0 && !hold_sender) begin
			quad_t q;
			q = pending_quads.pop_front();
			quad.valid <= 1'b1;
			quad.x0 <= q.x[0]; quad.y0 <= q.y[0];
			quad.x1 <= q.x[1]; quad.y1 <= q.y[1];
			quad.x2 <= q.x[2]; quad.y2 <= q.y[2];
			quad.x3 <= q.x[3]; quad.y3 <= q.y[3];
			if (!quiet_tail && $urandom_range(0, 5) == 0)
				send_gap <= $urandom_range(1, 13);
		end else begin
			quad.valid <= 1'b0;
		end
	end

	// Sink backpressure: random stall bursts
	int stall_left = 0;
	always @(negedge clk) begin
		if (!arst_n) begin
			ordered.ready <= 1'b0;
		end else if (stall_left > 0) begin
			stall_left <= stall_left - 1;
			ordered.ready <= 1'b0;
		end else if (!quiet_tail && $urandom_range(0, 7) == 0) begin
			stall_left <= $urandom_range(0, 12);
			ordered.ready <= 1'b0;
		end else begin
			ordered.ready <= 1'b1;
		end
	end

	// Monitor: predict on each accepted input, check each accepted output
	always @(posedge clk) begin
		if (arst_n && quad.valid && quad.ready) begin
			quad_t q;
			q.x = '{quad.x0, quad.x1, quad.x2, quad.x3};
			q.y = '{quad.y0, quad.y1, quad.y2, quad.y3};
			expected_orders.insert(expected_orders.size(), order_quad(q));
		end
		if (arst_n && ordered.valid && ordered.ready) begin
			quad_t got, exp_q;
			got.x = '{ordered.x0, ordered.x1, ordered.x2, ordered.x3};
			got.y = '{ordered.y0, ordered.y1, ordered.y2, ordered.y3};
			if (expected_orders.size() == 0) begin
				$display("%0t: unexpected word x0=%0d y0=%0d", $time, got.x[0], got.y[0]);
				fail_count++;
			end else begin
				exp_q = expected_orders.pop_front();
				for (int i = 0; i < 4; i++) begin
					if (got.x[i] !== exp_q.x[i]) begin
						$display("%0t: out_x%0d expected %0d actual %0d",
							$time, i, exp_q.x[i], got.x[i]);
						fail_count++;
					end
					if (got.y[i] !== exp_q.y[i]) begin
						$display("%0t: out_y%0d expected %0d actual %0d",
							$time, i, exp_q.y[i], got.y[i]);
						fail_count++;
					end
				end
			end
		end
	end

	// Directed corners first, then random quads; one full drain mid-run
	initial begin
		int d[$][8];
		quad.valid = 1'b0;
		{quad.x0, quad.y0, quad.x1, quad.y1, quad.x2, quad.y2, quad.x3, quad.y3} = '0;
		ordered.ready = 1'b0;
		d.insert(d.size(), '{10, 10, 20, 10, 20, 20, 10, 20});       // axis square
		d.insert(d.size(), '{20, 20, 10, 20, 10, 10, 20, 10});       // reversed, tie on top
		d.insert(d.size(), '{0, 0, 0, 0, 0, 0, 0, 0});               // all equal
		d.insert(d.size(), '{65535, 65535, 65535, 65535, 65535, 65535, 65535, 65535});
		d.insert(d.size(), '{0, 0, 65535, 0, 65535, 65535, 0, 65535}); // full-range extremes
		d.insert(d.size(), '{65535, 0, 0, 65535, 65535, 65535, 0, 0});
		d.insert(d.size(), '{50, 0, 100, 50, 50, 100, 0, 50});        // diamond
		d.insert(d.size(), '{0, 0, 10, 10, 20, 20, 30, 30});          // collinear diagonal
		d.insert(d.size(), '{5, 5, 10, 5, 15, 5, 20, 5});             // collinear row right
		d.insert(d.size(), '{20, 5, 15, 5, 10, 5, 5, 5});             // collinear row left
		d.insert(d.size(), '{5, 0, 5, 10, 5, 20, 5, 30});             // straight down
		d.insert(d.size(), '{10, 10, 10, 10, 30, 40, 0, 40});         // duplicate pivot
		d.insert(d.size(), '{10, 10, 30, 40, 30, 40, 0, 40});         // duplicate far
		d.insert(d.size(), '{10, 0, 20, 10, 30, 20, 0, 10});          // equal angle below ref
		d.insert(d.size(), '{10, 0, 0, 10, 20, 10, 5, 5});            // concave
		d.insert(d.size(), '{100, 3, 90, 3, 110, 3, 100, 50});        // pivot tie on y, sides
		d.insert(d.size(), '{43690, 21845, 21845, 43690, 0, 65535, 65535, 0});
		d.insert(d.size(), '{1, 2, 4, 8, 16, 32, 64, 128});
		foreach (d[i])
			pending_quads.insert(pending_quads.size(), pack_quad(d[i]));
		repeat (4) @(posedge clk);
		@(negedge clk) arst_n = 1'b1;
		for (int n = 0; n < 1100; n++) begin
			pending_quads.insert(pending_quads.size(), rand_quad());
			if (n == 400) begin
				// pause the sender until the pipe has fully drained
				wait (pending_quads.size() == 0);
				hold_sender = 1;
				wait (expected_orders.size() == 0 && !quad.valid);
				@(negedge clk) hold_sender = 0;
			end
			if (n == 950) begin
				// run the last words without idling
				wait (pending_quads.size() == 0);
				quiet_tail = 1;
			end
		end
		wait (pending_quads.size() == 0 && !quad.valid);
		wait (expected_orders.size() == 0);
		repeat (20) @(posedge clk);
		if (fail_count == 0)
			$display("Test completed successfully");
		else
			$display("Test completed with failures");
		$finish;
	end

	initial begin
		#2000000;
		$display("Test completed with failures");
		$finish;
	end

endmodule

>>> sim.f
+incdir+sv
sv/qvco_pkg.sv
sv/qvco_if.sv
sv/qvco_sort.sv
sv/quad_vertex_clockwise_order.sv
tb/sv/tb_quad_vertex_clockwise_order.sv
